// ===== rtl/core/dictionary_3bit_packer_top_macros.svh =====
// Assertion macros for the dictionary 3-bit packer.
`ifndef DICTIONARY_3BIT_PACKER_TOP_MACROS_SVH
`define DICTIONARY_3BIT_PACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define D3BP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define D3BP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define D3BP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define D3BP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/d3bp_pkg.sv =====
// Package with constants and helper functions for the dictionary 3-bit packer.
`timescale 1ns / 1ps

package d3bp_pkg;

  localparam int CHAR_W      = 8;
  localparam int CODE_W      = 3;
  localparam int DICT_SIZE   = 7;
  localparam int DICT_W      = DICT_SIZE * CHAR_W;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DICT_CHARS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DICT_COUNT = 1'd1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CODE_W-1:0] DICT_COUNT_RESET = 3'd7;

  // Slot positions within the three-byte group of eight codes.
  localparam logic [2:0] PHASE_BYTE0_HI  = 3'd0;
  localparam logic [2:0] PHASE_BYTE0_MID = 3'd1;
  localparam logic [2:0] PHASE_SPLIT_A   = 3'd2;
  localparam logic [2:0] PHASE_BYTE1_HI  = 3'd3;
  localparam logic [2:0] PHASE_BYTE1_MID = 3'd4;
  localparam logic [2:0] PHASE_SPLIT_B   = 3'd5;
  localparam logic [2:0] PHASE_BYTE2_HI  = 3'd6;
  localparam logic [2:0] PHASE_BYTE2_END = 3'd7;

  // Bits that a newline sets to one for the rest of the current slot.
  function automatic logic [CHAR_W-1:0] fill_mask(input logic [2:0] phase);
    logic [CHAR_W-1:0] mask;
    case (phase)
      PHASE_BYTE0_HI:  mask = 8'hE0;
      PHASE_BYTE0_MID: mask = 8'h1C;
      PHASE_SPLIT_A:   mask = 8'h03;
      PHASE_BYTE1_HI:  mask = 8'h70;
      PHASE_BYTE1_MID: mask = 8'h0E;
      PHASE_SPLIT_B:   mask = 8'h01;
      PHASE_BYTE2_HI:  mask = 8'h38;
      PHASE_BYTE2_END: mask = 8'h07;
      default:         mask = 8'h00;
    endcase
    return mask;
  endfunction

endpackage

// ===== rtl/core/dictionary_3bit_packer_top.sv =====
// Top level of the dictionary 3-bit packer: lookup, bit packing and output register.
//
// Usage: one character enters per transaction on char_in (in_valid/in_ready).
// Each character is matched against up to seven dictionary bytes held in
// cfg register 0, limited to the first dictionary_count entries (register 1);
// the lowest matching index wins and an unmatched character codes as 0.
// Codes are packed MSB first, eight codes to three bytes; each completed
// byte leaves as one transaction on packed_byte/last_byte (out_valid/out_ready).
// A newline pads the current slot with ones, sends that byte with last_byte
// set and restarts the group.
// A character that completes a byte is held in the input register; its byte then
// moves to the output register, raising out_valid. The combinational compare and
// pack step between them passes one character per cycle while the output is free.
// When the receiver stalls, the output register holds its byte and the input
// register keeps taking characters that produce no byte; one that would
// produce a byte waits there, and in_ready falls until the output frees up.
// Reset (rst, synchronous) empties both registers, clears the packing state and
// sets the dictionary to all zero bytes with a count of seven. The user must write
// configuration only while no transaction is in flight; the block does not check.
`timescale 1ns / 1ps

`include "dictionary_3bit_packer_top_macros.svh"

module dictionary_3bit_packer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [d3bp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [d3bp_pkg::DICT_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [d3bp_pkg::CHAR_W-1:0]          char_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [d3bp_pkg::CHAR_W-1:0]          packed_byte,
  output logic                                 last_byte
);
  import d3bp_pkg::*;

  logic [DICT_W-1:0]     dict_chars;
  logic [CODE_W-1:0]     dict_count;
  logic                  s1_valid;
  logic [CHAR_W-1:0]     s1_char;
  logic [2:0]            slot_phase;
  logic [2:0]            slot_phase_next;
  logic [CHAR_W-1:0]     partial_byte;
  logic [CHAR_W-1:0]     partial_byte_next;
  logic [CHAR_W-1:0]     byte_out;
  logic [CODE_W-1:0]     code;
  logic [CHAR_W-1:0]     code8;
  logic                  is_newline;
  logic                  emit;
  logic                  out_free;
  logic                  s1_go;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dict_chars <= '0;
      dict_count <= DICT_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DICT_CHARS: dict_chars <= cfg_data;
        CFG_DICT_COUNT: dict_count <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Parallel dictionary compare; the lowest matching index wins.
  always_comb begin
    code = '0;
    for (int k = DICT_SIZE - 1; k >= 0; k--) begin
      if ((CODE_W'(k) < dict_count) && (dict_chars[k*CHAR_W +: CHAR_W] == s1_char)) begin
        code = CODE_W'(k);
      end
    end
  end

  assign code8      = {{(CHAR_W-CODE_W){1'b0}}, code};
  assign is_newline = (s1_char == NEWLINE_CHAR);

  // Place the code in its slot and decide whether a byte completes.
  always_comb begin
    partial_byte_next = partial_byte;
    byte_out          = partial_byte;
    emit              = 1'b0;
    slot_phase_next   = slot_phase + 3'd1;
    if (is_newline) begin
      byte_out          = partial_byte | fill_mask(slot_phase);
      partial_byte_next = '0;
      slot_phase_next   = PHASE_BYTE0_HI;
      emit              = 1'b1;
    end else begin
      case (slot_phase)
        PHASE_BYTE0_HI:  partial_byte_next = partial_byte | (code8 << 5);
        PHASE_BYTE0_MID: partial_byte_next = partial_byte | (code8 << 2);
        PHASE_SPLIT_A: begin
          byte_out          = partial_byte | (code8 >> 1);
          partial_byte_next = {code[0], 7'b0};
          emit              = 1'b1;
        end
        PHASE_BYTE1_HI:  partial_byte_next = partial_byte | (code8 << 4);
        PHASE_BYTE1_MID: partial_byte_next = partial_byte | (code8 << 1);
        PHASE_SPLIT_B: begin
          byte_out          = partial_byte | (code8 >> 2);
          partial_byte_next = {code[1:0], 6'b0};
          emit              = 1'b1;
        end
        PHASE_BYTE2_HI:  partial_byte_next = partial_byte | (code8 << 3);
        PHASE_BYTE2_END: begin
          byte_out          = partial_byte | code8;
          partial_byte_next = '0;
          emit              = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on unless it holds a byte with nowhere to go.
  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!emit || out_free);
  assign in_ready = !s1_valid || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char <= char_in;
    end
  end

  // Packing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_phase   <= PHASE_BYTE0_HI;
      partial_byte <= '0;
    end else if (s1_go) begin
      slot_phase   <= slot_phase_next;
      partial_byte <= partial_byte_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && emit) begin
      packed_byte <= byte_out;
      last_byte   <= is_newline;
    end
  end

  // A newline always returns the packer to the start of a group.
  `D3BP_ASSERT_NEXT(a_newline_restarts, clk, rst, s1_go && is_newline, slot_phase == PHASE_BYTE0_HI && partial_byte == '0)
  // A byte without the last mark completes only at the byte-closing slots.
  `D3BP_ASSERT_IMPLY(a_emit_phase, clk, rst, s1_go && emit && !is_newline, slot_phase == PHASE_SPLIT_A || slot_phase == PHASE_SPLIT_B || slot_phase == PHASE_BYTE2_END)
  // At the start of a group no bits are pending.
  `D3BP_ASSERT_IMPLY(a_group_start_empty, clk, rst, slot_phase == PHASE_BYTE0_HI, partial_byte == '0)
  // The input side stalls only while a character waits in the input register.
  `D3BP_ASSERT_IMPLY(a_stall_has_item, clk, rst, !in_ready, s1_valid && emit && out_valid)

endmodule
